### rtl/mpst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpst_pkg: shared definitions for the phase sequence timer
// Phase codes, register indexes, duration limits and small helper functions.
// ----------------------------------------------------------------------------
package mpst_pkg;

    typedef logic [2:0]  phase_t;
    typedef logic [23:0] dur_t;
    typedef logic [2:0]  cfg_idx_t;

    localparam phase_t PH_INTRO  = 3'd0;
    localparam phase_t PH_WORK   = 3'd1;
    localparam phase_t PH_VOTE   = 3'd2;
    localparam phase_t PH_SETTLE = 3'd3;
    localparam phase_t PH_ENDED  = 3'd4;

    localparam cfg_idx_t CFG_CYCLE_LIMIT = 3'd0;
    localparam cfg_idx_t CFG_INTRO_TIME  = 3'd1;
    localparam cfg_idx_t CFG_WORK_TIME   = 3'd2;
    localparam cfg_idx_t CFG_VOTE_TIME   = 3'd3;
    localparam cfg_idx_t CFG_SETTLE_TIME = 3'd4;
    localparam cfg_idx_t CFG_HOUR_START  = 3'd5;
    localparam cfg_idx_t CFG_HOUR_END    = 3'd6;

    localparam dur_t        MIN_DUR = 24'd1024;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    function automatic dur_t at_least_min(dur_t v);
        return (v < MIN_DUR) ? MIN_DUR : v;
    endfunction

    function automatic dur_t dur_of(phase_t ph, dur_t t_intro, dur_t t_work,
                                    dur_t t_vote, dur_t t_settle);
        dur_t d;
        case (ph)
            PH_INTRO:  d = at_least_min(t_intro);
            PH_WORK:   d = at_least_min(t_work);
            PH_VOTE:   d = at_least_min(t_vote);
            PH_SETTLE: d = at_least_min(t_settle);
            default:   d = '0;
        endcase
        return d;
    endfunction

    function automatic phase_t succ_of(phase_t ph);
        phase_t s;
        case (ph)
            PH_INTRO:  s = PH_WORK;
            PH_WORK:   s = PH_VOTE;
            PH_VOTE:   s = PH_SETTLE;
            PH_SETTLE: s = PH_WORK;
            default:   s = PH_ENDED;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/mpst_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpst_div: serial restoring divider for phase progress
// Computes floor(numer * 2^16 / denom) for numer < denom, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module mpst_div
    import mpst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire dur_t        numer,
    input  wire dur_t        denom,
    output logic             done,
    output logic [15:0]      quotient
);

    logic        busy_reg, busy_next;
    logic [3:0]  count_reg, count_next;
    dur_t        rem_reg, rem_next;
    dur_t        denom_reg, denom_next;
    logic [15:0] quo_reg, quo_next;
    logic [24:0] shifted;
    logic [24:0] trial;
    logic        ge;

    always_comb
    begin
        shifted    = {rem_reg, 1'b0};
        ge         = shifted >= {1'b0, denom_reg};
        trial      = shifted - {1'b0, denom_reg};
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        denom_next = denom_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = 4'hF;
            rem_next   = numer;
            denom_next = denom;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? trial[23:0] : shifted[23:0];
            quo_next   = {quo_reg[14:0], ge};
            count_next = count_reg - 4'd1;
            if (count_reg == 4'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
        quo_reg   <= quo_next;
    end

    assign done     = busy_reg && (count_reg == 4'd0);
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### rtl/multi_phase_sequence_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_phase_sequence_timer: timed phase sequencer
// Flow: an accepted request updates the phase, then steps through prep, the
// serial progress divide, multiply and hour states before the result is
// valid. No new request until the result is taken.
// Reset: phase intro, elapsed 0, cycle 1, registers at their documented
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module multi_phase_sequence_timer
    import mpst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [23:0] delta_time,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             fired,
    output logic [2:0]       from_phase,
    output logic [2:0]       to_phase,
    output logic [7:0]       cycle_number,
    output logic             cycle_advanced,
    output logic             sequence_ended,
    output logic [23:0]      remaining_time,
    output logic [16:0]      progress,
    output logic [12:0]      hour_now,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_HOUR = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [7:0]  cycle_limit_reg;
    dur_t        intro_time_reg, work_time_reg, vote_time_reg, settle_time_reg;
    logic [12:0] hour_start_reg, hour_end_reg;

    logic [2:0]  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [7:0]  cycle_count_reg, cycle_count_next;

    logic        fired_reg, fired_next;
    phase_t      from_reg, from_next;
    logic        adv_reg, adv_next;
    dur_t        remaining_reg, remaining_next;
    logic [16:0] progress_reg, progress_next;
    logic [12:0] hour_reg, hour_next;
    logic        cap_reg, cap_next;
    logic        zero_reg, zero_next;
    logic signed [31:0] prod_reg, prod_next;

    logic        in_accept;
    logic        positive;
    phase_t      from_ph;
    phase_t      to_ph;
    logic [32:0] sum_wide;
    logic [31:0] sum_sat;
    dur_t        dur_from;
    dur_t        dur_cur;
    logic [7:0]  lim;
    logic        cur_ended;
    logic        cur_cap;
    logic        div_start;
    dur_t        div_numer;
    logic        div_done;
    logic [15:0] div_quo;
    logic signed [13:0] hour_diff;
    logic [15:0] hour_mix;

    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_limit_reg <= 8'd1;
            intro_time_reg  <= MIN_DUR;
            work_time_reg   <= MIN_DUR;
            vote_time_reg   <= MIN_DUR;
            settle_time_reg <= MIN_DUR;
            hour_start_reg  <= 13'd0;
            hour_end_reg    <= 13'd6144;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CYCLE_LIMIT: cycle_limit_reg <= cfg_data[7:0];
                CFG_INTRO_TIME:  intro_time_reg  <= cfg_data;
                CFG_WORK_TIME:   work_time_reg   <= cfg_data;
                CFG_VOTE_TIME:   vote_time_reg   <= cfg_data;
                CFG_SETTLE_TIME: settle_time_reg <= cfg_data;
                CFG_HOUR_START:  hour_start_reg  <= cfg_data[12:0];
                CFG_HOUR_END:    hour_end_reg    <= cfg_data[12:0];
                default:         ;
            endcase
        end
    end

    // request update: one transition at most
    always_comb
    begin
        positive  = (delta_time != 24'd0) && !delta_time[23];
        from_ph   = (phase_reg > PH_ENDED) ? PH_ENDED : phase_reg;
        sum_wide  = {1'b0, elapsed_reg} + {10'd0, delta_time[22:0]};
        sum_sat   = sum_wide[32] ? '1 : sum_wide[31:0];
        dur_from  = dur_of(from_ph, intro_time_reg, work_time_reg,
                           vote_time_reg, settle_time_reg);
        lim       = (cycle_limit_reg == 8'd0) ? 8'd1 : cycle_limit_reg;
        to_ph     = from_ph;

        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        cycle_count_next = cycle_count_reg;
        fired_next       = fired_reg;
        from_next        = from_reg;
        adv_next         = adv_reg;

        if (in_accept)
        begin
            fired_next = 1'b0;
            adv_next   = 1'b0;
            from_next  = from_ph;
            if (operation)
            begin
                to_ph        = PH_ENDED;
                elapsed_next = '0;
            end
            else if ((from_ph != PH_ENDED) && positive)
            begin
                elapsed_next = sum_sat;
                if (sum_sat >= {8'd0, dur_from})
                begin
                    elapsed_next = sum_sat - {8'd0, dur_from};
                    to_ph        = succ_of(from_ph);
                    if (from_ph == PH_SETTLE)
                    begin
                        if (cycle_count_reg >= lim)
                        begin
                            to_ph = PH_ENDED;
                        end
                        else
                        begin
                            cycle_count_next = cycle_count_reg + 8'd1;
                            adv_next         = 1'b1;
                        end
                    end
                    if (to_ph == PH_ENDED)
                    begin
                        elapsed_next = '0;
                    end
                    fired_next = 1'b1;
                end
            end
            phase_next = to_ph;
        end
    end

    // progress, remaining and hour
    always_comb
    begin
        dur_cur   = dur_of(phase_reg, intro_time_reg, work_time_reg,
                           vote_time_reg, settle_time_reg);
        cur_ended = phase_reg >= PH_ENDED;
        cur_cap   = elapsed_reg >= {8'd0, dur_cur};
        div_start = 1'b0;
        div_numer = '0;
        hour_diff = $signed({1'b0, hour_end_reg}) - $signed({1'b0, hour_start_reg});
        hour_mix  = {3'd0, hour_start_reg} + prod_reg[31:16];

        state_next     = state_reg;
        remaining_next = remaining_reg;
        progress_next  = progress_reg;
        hour_next      = hour_reg;
        cap_next       = cap_reg;
        zero_next      = zero_reg;
        prod_next      = prod_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                zero_next = cur_ended;
                cap_next  = cur_cap;
                if (cur_ended || cur_cap)
                begin
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = dur_cur - elapsed_reg[23:0];
                    div_numer      = elapsed_reg[23:0];
                end
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (zero_reg)
                begin
                    progress_next = '0;
                end
                else if (cap_reg)
                begin
                    progress_next = ONE_Q16;
                end
                else
                begin
                    progress_next = {1'b0, div_quo};
                end
                prod_next  = 32'(hour_diff) * 32'($signed({1'b0, progress_next}));
                state_next = S_HOUR;
            end
            S_HOUR:
            begin
                case (phase_reg)
                    PH_INTRO: hour_next = hour_start_reg;
                    PH_WORK:  hour_next = hour_mix[12:0];
                    default:  hour_next = hour_end_reg;
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    mpst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (dur_cur),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_INTRO;
            elapsed_reg     <= '0;
            cycle_count_reg <= 8'd1;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            elapsed_reg     <= elapsed_next;
            cycle_count_reg <= cycle_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg     <= fired_next;
        from_reg      <= from_next;
        adv_reg       <= adv_next;
        remaining_reg <= remaining_next;
        progress_reg  <= progress_next;
        hour_reg      <= hour_next;
        cap_reg       <= cap_next;
        zero_reg      <= zero_next;
        prod_reg      <= prod_next;
    end

    assign in_stall       = state_reg != S_IDLE;
    assign out_valid      = state_reg == S_DONE;
    assign fired          = fired_reg;
    assign from_phase     = from_reg;
    assign to_phase       = phase_reg;
    assign cycle_number   = cycle_count_reg;
    assign cycle_advanced = adv_reg;
    assign sequence_ended = phase_reg == PH_ENDED;
    assign remaining_time = remaining_reg;
    assign progress       = progress_reg;
    assign hour_now       = hour_reg;

endmodule
`default_nettype wire

### rtl/mpst_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpst_checker: port-level checks for the phase sequence timer
// Watches requests and results at the top level ports; bound to the top.
// ----------------------------------------------------------------------------
module mpst_checker
    import mpst_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        fired,
    input wire logic [2:0]  from_phase,
    input wire logic [2:0]  to_phase,
    input wire logic        cycle_advanced,
    input wire logic        sequence_ended,
    input wire logic [23:0] remaining_time,
    input wire logic [16:0] progress,
    input wire logic [12:0] hour_now
);

    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fired) && $stable(to_phase)
            && $stable(remaining_time) && $stable(progress) && $stable(hour_now);
    endproperty
    a_result_holds: assert property (p_result_holds) else $error("result changed while stalled");

    property p_busy_after_request;
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid;
    endproperty
    a_busy_after_request: assert property (p_busy_after_request)
        else $error("not busy after request");

    property p_pending_blocks;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall;
    endproperty
    a_pending_blocks: assert property (p_pending_blocks)
        else $error("request taken while result pending");

    property p_advance;
        @(posedge clk) disable iff (!rst_n)
        out_valid && cycle_advanced |-> fired && from_phase == PH_SETTLE
            && to_phase == PH_WORK;
    endproperty
    a_advance: assert property (p_advance) else $error("bad cycle advance");

    property p_ended;
        @(posedge clk) disable iff (!rst_n)
        out_valid && sequence_ended |-> to_phase == PH_ENDED && remaining_time == 24'd0
            && progress == 17'd0;
    endproperty
    a_ended: assert property (p_ended) else $error("bad ended result");

endmodule

bind multi_phase_sequence_timer mpst_checker u_mpst_checker (.*);
`default_nettype wire

### test/tb_multi_phase_sequence_timer.sv
// ----------------------------------------------------------------------------
// tb_multi_phase_sequence_timer: self-checking bench for the phase timer
// Sends tick and force-end requests with random idling on both channels, runs
// a local model of the phase sequencer for each accepted request and checks
// every returned report field by field, in order, across several register
// settings from the reset defaults through to the terminal ended phase.
// ----------------------------------------------------------------------------
module tb_multi_phase_sequence_timer
    import mpst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_END  = 1'b1;
    localparam int   DRAIN_CYCLES = 30;
    localparam int   CYCLE_CAP    = 400000;
    localparam logic [23:0] MAX_STEP = 24'h7FFFFF;

    typedef struct packed {
        logic        fired;
        phase_t      from_ph;
        phase_t      to_ph;
        logic [7:0]  cycle;
        logic        advanced;
        logic        ended;
        logic [23:0] remaining;
        logic [16:0] prog;
        logic [12:0] hour;
    } phase_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [23:0] delta_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        fired;
    logic [2:0]  from_phase;
    logic [2:0]  to_phase;
    logic [7:0]  cycle_number;
    logic        cycle_advanced;
    logic        sequence_ended;
    logic [23:0] remaining_time;
    logic [16:0] progress;
    logic [12:0] hour_now;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // model state and register copies
    phase_t      cur_phase = PH_INTRO;
    logic [31:0] phase_elapsed = '0;
    logic [7:0]  cycle_cnt = 8'd1;
    logic [7:0]  limit_cfg = 8'd1;
    dur_t        intro_cfg = 24'd1024;
    dur_t        work_cfg = 24'd1024;
    dur_t        vote_cfg = 24'd1024;
    dur_t        settle_cfg = 24'd1024;
    logic [12:0] hour_start_cfg = 13'd0;
    logic [12:0] hour_end_cfg = 13'd6144;

    phase_report_t pending_reports[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_total = 0;
    bit            steady_run = 1'b0;

    multi_phase_sequence_timer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .delta_time     (delta_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fired          (fired),
        .from_phase     (from_phase),
        .to_phase       (to_phase),
        .cycle_number   (cycle_number),
        .cycle_advanced (cycle_advanced),
        .sequence_ended (sequence_ended),
        .remaining_time (remaining_time),
        .progress       (progress),
        .hour_now       (hour_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] phase_span(phase_t ph);
        dur_t raw;
        case (ph)
            PH_INTRO:  raw = intro_cfg;
            PH_WORK:   raw = work_cfg;
            PH_VOTE:   raw = vote_cfg;
            PH_SETTLE: raw = settle_cfg;
            default:   return 32'd0;
        endcase
        return (raw < MIN_DUR) ? 32'(MIN_DUR) : 32'(raw);
    endfunction

    function automatic phase_t next_phase(phase_t ph);
        case (ph)
            PH_INTRO:  return PH_WORK;
            PH_WORK:   return PH_VOTE;
            PH_VOTE:   return PH_SETTLE;
            PH_SETTLE: return PH_WORK;
            default:   return PH_ENDED;
        endcase
    endfunction

    function automatic phase_report_t step_sequencer(logic op, logic [23:0] dt);
        phase_report_t r;
        phase_t        from_ph;
        phase_t        to_ph;
        logic [32:0]   sum;
        logic [31:0]   span;
        logic [47:0]   quot;
        logic [47:0]   mix;
        logic [7:0]    lim;
        r = '0;
        from_ph = (cur_phase > PH_ENDED) ? PH_ENDED : cur_phase;
        to_ph = from_ph;
        if (op == OP_END)
        begin
            to_ph = PH_ENDED;
            phase_elapsed = '0;
        end
        else if (from_ph != PH_ENDED && dt != '0 && !dt[23])
        begin
            span = phase_span(from_ph);
            sum = {1'b0, phase_elapsed} + {9'd0, dt};
            phase_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (phase_elapsed >= span)
            begin
                lim = (limit_cfg == 8'd0) ? 8'd1 : limit_cfg;
                phase_elapsed = phase_elapsed - span;
                to_ph = next_phase(from_ph);
                if (from_ph == PH_SETTLE)
                begin
                    if (cycle_cnt >= lim)
                    begin
                        to_ph = PH_ENDED;
                    end
                    else
                    begin
                        cycle_cnt = cycle_cnt + 8'd1;
                        r.advanced = 1'b1;
                    end
                end
                if (to_ph == PH_ENDED)
                    phase_elapsed = '0;
                r.fired = 1'b1;
            end
        end
        cur_phase = to_ph;
        if (to_ph != PH_ENDED)
        begin
            span = phase_span(to_ph);
            r.remaining = (phase_elapsed < span) ? 24'(span - phase_elapsed) : 24'd0;
            quot = {phase_elapsed, 16'd0} / 48'(span);
            r.prog = (quot > 48'(ONE_Q16)) ? ONE_Q16 : quot[16:0];
        end
        case (to_ph)
            PH_INTRO: r.hour = hour_start_cfg;
            PH_WORK:
            begin
                mix = 48'(hour_start_cfg) * 48'(ONE_Q16 - r.prog)
                    + 48'(hour_end_cfg) * 48'(r.prog);
                r.hour = mix[28:16];
            end
            default:  r.hour = hour_end_cfg;
        endcase
        r.from_ph = from_ph;
        r.to_ph = to_ph;
        r.cycle = cycle_cnt;
        r.ended = (to_ph == PH_ENDED);
        return r;
    endfunction

    // tick length chosen against the time left in the current phase
    function automatic logic [23:0] pick_delta(bit wide);
        logic [31:0]  span;
        logic [31:0]  rem;
        logic [31:0]  d;
        int unsigned  sel;
        span = phase_span(cur_phase);
        rem = (phase_elapsed < span) ? span - phase_elapsed : 32'd0;
        sel = $urandom_range(99);
        if (sel < 4)
            return 24'd0;
        if (sel < 10)
            return {1'b1, 23'($urandom)};
        if (sel < 50)
            d = 1 + $urandom_range(span / 4);
        else if (sel < 78)
            d = (rem == 0) ? 1 + $urandom_range(3) : rem - 1 + $urandom_range(2);
        else if (sel < 88)
            d = rem + $urandom_range(2 * span);
        else if (wide)
            return 24'($urandom);
        else
            d = 1 + $urandom_range(span);
        if (d > 32'(MAX_STEP))
            d = 32'(MAX_STEP);
        return d[23:0];
    endfunction

    function automatic dur_t rand_dur(int unsigned top);
        return 24'($urandom_range(top));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_report();
        phase_report_t want;
        if (pending_reports.size() == 0)
        begin
            report_mismatch("report with no request outstanding", 0, 0);
        end
        else
        begin
            want = pending_reports.pop_front();
            if (fired !== want.fired)
                report_mismatch("fired", fired, want.fired);
            if (from_phase !== want.from_ph)
                report_mismatch("from_phase", from_phase, want.from_ph);
            if (to_phase !== want.to_ph)
                report_mismatch("to_phase", to_phase, want.to_ph);
            if (cycle_number !== want.cycle)
                report_mismatch("cycle_number", cycle_number, want.cycle);
            if (cycle_advanced !== want.advanced)
                report_mismatch("cycle_advanced", cycle_advanced, want.advanced);
            if (sequence_ended !== want.ended)
                report_mismatch("sequence_ended", sequence_ended, want.ended);
            if (remaining_time !== want.remaining)
                report_mismatch("remaining_time", remaining_time, want.remaining);
            if (progress !== want.prog)
                report_mismatch("progress", progress, want.prog);
            if (hour_now !== want.hour)
                report_mismatch("hour_now", hour_now, want.hour);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_report();
        out_stall <= !steady_run && ($urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        cycle_total++;
        if (cycle_total > CYCLE_CAP)
        begin
            $display("timeout with %0d reports outstanding", pending_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [23:0] dt);
        while (!steady_run && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        delta_time <= dt;
        do @(posedge clk); while (in_stall);
        pending_reports.push_back(step_sequencer(op, dt));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_CYCLE_LIMIT: limit_cfg = val[7:0];
            CFG_INTRO_TIME:  intro_cfg = val;
            CFG_WORK_TIME:   work_cfg = val;
            CFG_VOTE_TIME:   vote_cfg = val;
            CFG_SETTLE_TIME: settle_cfg = val;
            CFG_HOUR_START:  hour_start_cfg = val[12:0];
            CFG_HOUR_END:    hour_end_cfg = val[12:0];
            default:         ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] lim, input dur_t ti, input dur_t tw,
                                input dur_t tv, input dur_t ts,
                                input logic [12:0] hs, input logic [12:0] he);
        write_reg(CFG_CYCLE_LIMIT, {16'd0, lim});
        write_reg(CFG_INTRO_TIME, ti);
        write_reg(CFG_WORK_TIME, tw);
        write_reg(CFG_VOTE_TIME, tv);
        write_reg(CFG_SETTLE_TIME, ts);
        write_reg(CFG_HOUR_START, {11'd0, hs});
        write_reg(CFG_HOUR_END, {11'd0, he});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_ticks(input int n, input bit wide);
        for (int i = 0; i < n; i++)
            send_request(OP_TICK, pick_delta(wide));
    endtask

    // reset defaults: limit 1, so stop short of leaving settle
    task automatic test_default_sequence();
        send_request(OP_TICK, 24'd0);
        send_request(OP_TICK, 24'hFFFFFF);
        send_request(OP_TICK, 24'h800000);
        send_request(OP_TICK, 24'd1);
        send_request(OP_TICK, 24'd1023);
        send_request(OP_TICK, 24'd512);
        send_request(OP_TICK, 24'd511);
        send_request(OP_TICK, 24'd1);
        send_request(OP_TICK, 24'd1024);
        send_request(OP_TICK, 24'd1023);
        wait_idle();
    endtask

    // overshoot past the next phase, capped progress, reversed hours
    task automatic test_overshoot_and_extremes();
        program_regs(8'd255, 24'd0, 24'd1023, 24'd4096, 24'hFFFFFF, 13'd6144, 13'd0);
        send_request(OP_TICK, MAX_STEP);
        send_request(OP_TICK, MAX_STEP);
        send_request(OP_TICK, 24'd10024);
        send_request(OP_TICK, 24'd1);
        send_request(OP_TICK, MAX_STEP);
        send_request(OP_TICK, MAX_STEP);
        send_request(OP_TICK, 24'd1);
        send_request(OP_TICK, 24'd1);
        wait_idle();
    endtask

    task automatic test_short_phases();
        program_regs(8'd255, rand_dur(4000), rand_dur(4000), rand_dur(4000),
                     rand_dur(4000), 13'($urandom_range(6144)), 13'($urandom_range(6144)));
        run_ticks(150, 1'b0);
        wait_idle();
    endtask

    task automatic test_long_phases();
        program_regs(8'd254, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                     13'd0, 13'd6144);
        run_ticks(150, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 2; k++)
        begin
            program_regs(8'($urandom_range(200, 255)), 24'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom), 13'($urandom), 13'($urandom));
            run_ticks(150, 1'b0);
            wait_idle();
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        program_regs(8'd255, 24'd1024, 24'd1024, 24'd1024, 24'd1024, 13'd6144, 13'd0);
        steady_run = 1'b1;
        run_ticks(120, 1'b0);
        wait_idle();
        steady_run = 1'b0;
    endtask

    // limit of 0 acts as 1, below the count: next settle ends the run
    task automatic test_limit_and_end();
        logic [31:0] span;
        logic [31:0] rem;
        program_regs(8'd0, 24'd0, 24'd0, 24'd0, 24'd0, 13'd8191, 13'd8191);
        while (cur_phase != PH_ENDED)
        begin
            span = phase_span(cur_phase);
            rem = (phase_elapsed < span) ? span - phase_elapsed : 32'd1;
            send_request(OP_TICK, (rem > 32'(MAX_STEP)) ? MAX_STEP : rem[23:0]);
        end
        send_request(OP_TICK, MAX_STEP);
        send_request(OP_TICK, 24'd1);
        send_request(OP_TICK, 24'd0);
        send_request(OP_TICK, 24'hFFFFFF);
        send_request(OP_END, MAX_STEP);
        send_request(OP_END, 24'd0);
        send_request(OP_END, 24'h800000);
        send_request(OP_TICK, 24'd1);
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_sequence();
        test_overshoot_and_extremes();
        test_short_phases();
        test_long_phases();
        test_random_settings();
        test_back_to_back();
        test_limit_and_end();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
